// ===== hw/rtl/wrs_pkg.sv =====
// Shared types and constants for the weighted random select block.
package wrs_pkg;

    localparam int WEIGHT_IN_W = 16;
    localparam int DRAW_W      = 16;
    localparam int IDX_W       = 6;
    localparam int MUL_CNT_W   = 4;   // counts the DRAW_W multiply steps

    typedef struct packed {
        logic [WEIGHT_IN_W-1:0] weight;
        logic [DRAW_W-1:0]      random_draw;
        logic                   last_weight;
    } t_wrs_in;

    typedef struct packed {
        logic [IDX_W-1:0] selected_index;
        logic             list_overflowed;
    } t_wrs_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCAN,
        ST_OUT
    } t_wrs_state;

endpackage

// ===== hw/rtl/wrs_wmem.sv =====
// Weight store: one write port, one registered read port.
module wrs_wmem #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/weighted_random_select.sv =====
// Roulette-wheel selection over a stored list of unsigned weights.
//
//   channel | direction | handshake                      | payload
//   --------+-----------+--------------------------------+----------
//   in      | input     | i_in_valid / o_in_stall        | t_wrs_in
//   out     | output    | o_out_valid / i_out_stall      | t_wrs_out
//
// A non-final weight is taken and the block stays ready for the next one.
// The final item starts a shift-add multiply (one draw bit per cycle on
// the shared adder) and then a prefix-sum scan that reads one stored
// weight per cycle. The input is stalled from the final item until its
// result is taken. Reset is synchronous and clears the list; the weight
// store is not cleared.
module weighted_random_select
    import wrs_pkg::*;
#(
    parameter int MAX_ITEMS   = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_wrs_in  i_in,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_wrs_out o_out
);

    localparam int AW    = $clog2(MAX_ITEMS);
    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam int TW    = WEIGHT_BITS + AW;
    localparam int ACC_W = TW + DRAW_W;

    t_wrs_state r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic [TW-1:0]        r_total, n_total;
    logic                 r_ovf, n_ovf;
    logic                 r_out_valid, n_out_valid;
    logic [MUL_CNT_W-1:0] r_mcnt, n_mcnt;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [DRAW_W-1:0]    r_draw, n_draw;
    logic [AW-1:0]        r_idx, n_idx;
    logic [TW-1:0]        r_prefix, n_prefix;
    t_wrs_out             r_out, n_out;

    logic [WEIGHT_BITS-1:0] w_eff;
    logic [WEIGHT_BITS-1:0] rdata;
    logic [AW-1:0]          rd_addr;
    logic                   mem_we;
    logic                   in_acc;
    logic [TW-1:0]          add_a, add_b;
    logic [TW:0]            add_sum;
    logic [TW-1:0]          thr;

    assign w_eff      = WEIGHT_BITS'(i_in.weight);
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign thr        = r_acc[ACC_W-1:DRAW_W];

    // the one adder, shared by loading, multiplying and scanning
    assign add_sum = {1'b0, add_a} + {1'b0, add_b};

    wrs_wmem #(
        .DEPTH  (MAX_ITEMS),
        .WIDTH  (WEIGHT_BITS),
        .ADDR_W (AW)
    ) u_wmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_eff),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_mcnt      <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_mcnt      <= n_mcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_draw   <= n_draw;
        r_idx    <= n_idx;
        r_prefix <= n_prefix;
        r_out    <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_total     = r_total;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_mcnt      = r_mcnt;
        n_acc       = r_acc;
        n_draw      = r_draw;
        n_idx       = r_idx;
        n_prefix    = r_prefix;
        n_out       = r_out;
        add_a       = '0;
        add_b       = '0;
        mem_we      = 1'b0;
        rd_addr     = '0;

        unique case (r_state)
            ST_IDLE: begin
                add_a = r_total;
                add_b = TW'(w_eff);
                if (in_acc) begin
                    if (r_count < CW'(MAX_ITEMS)) begin
                        mem_we  = 1'b1;
                        n_count = r_count + CW'(1);
                        n_total = add_sum[TW-1:0];
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.last_weight) begin
                        n_state = ST_MUL;
                        n_acc   = '0;
                        n_draw  = i_in.random_draw;
                        n_mcnt  = '0;
                    end
                end
            end

            ST_MUL: begin
                // LSB-first shift-add: high part accumulates, product shifts right
                add_a  = r_acc[ACC_W-1:DRAW_W];
                add_b  = r_draw[0] ? r_total : '0;
                n_acc  = {add_sum, r_acc[DRAW_W-1:1]};
                n_draw = r_draw >> 1;
                n_mcnt = r_mcnt + MUL_CNT_W'(1);
                // keep reading entry 0 so it is ready when the scan starts
                rd_addr = '0;
                if (r_mcnt == '1) begin
                    n_state  = ST_SCAN;
                    n_idx    = '0;
                    n_prefix = '0;
                end
            end

            ST_SCAN: begin
                add_a    = r_prefix;
                add_b    = TW'(rdata);
                n_prefix = add_sum[TW-1:0];
                n_idx    = r_idx + AW'(1);
                rd_addr  = r_idx + AW'(1);
                if ((add_sum >= {1'b0, thr}) ||
                    (CW'(r_idx) + CW'(1) == r_count)) begin
                    n_out.selected_index  = IDX_W'(r_idx);
                    n_out.list_overflowed = r_ovf;
                    n_out_valid = 1'b1;
                    n_count     = '0;
                    n_total     = '0;
                    n_ovf       = 1'b0;
                    n_state     = ST_OUT;
                end
            end

            ST_OUT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    n_state     = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
